/* hdl/lcsp_pkg.sv */
`default_nettype none

package lcsp_pkg;

    // Fixed field widths
    localparam int OP_BITS       = 3;
    localparam int SLOT_BITS     = 4;
    localparam int ADDR_BITS     = 32;
    localparam int PORT_BITS     = 16;
    localparam int IN_COUNT_BITS = 20;
    localparam int STATUS_BITS   = 2;
    localparam int TOTAL_BITS    = 24;

    // Operation codes
    localparam logic [OP_BITS-1:0] OP_REGISTER   = 3'd0;
    localparam logic [OP_BITS-1:0] OP_UNREGISTER = 3'd1;
    localparam logic [OP_BITS-1:0] OP_INCREMENT  = 3'd2;
    localparam logic [OP_BITS-1:0] OP_DECREMENT  = 3'd3;
    localparam logic [OP_BITS-1:0] OP_REQUEST    = 3'd4;

    // Status codes
    localparam logic [STATUS_BITS-1:0] ST_ASSIGNED  = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NO_SERVER = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_ALL_FULL  = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_UPDATE    = 2'd3;

    // Modes of the shared compare and total unit
    typedef enum logic [1:0] {
        ALU_SCAN,
        ALU_ADD,
        ALU_SUB
    } alu_mode_t;

    // Table port controls
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic set_valid;
        logic clr_valid;
    } tbl_ctl_t;

endpackage

`default_nettype wire

/* hdl/lcsp_alu.sv */
`default_nettype none

module lcsp_alu #(
    parameter int COUNT_BITS = 20
) (
    input  wire lcsp_pkg::alu_mode_t                mode,
    input  wire logic [COUNT_BITS-1:0]              users,
    input  wire logic [COUNT_BITS-1:0]              capacity,
    input  wire logic [COUNT_BITS-1:0]              best_users,
    input  wire logic [COUNT_BITS-1:0]              amount,
    input  wire logic [lcsp_pkg::TOTAL_BITS-1:0]    total,
    output logic                                    fits,
    output logic                                    better,
    output logic [lcsp_pkg::TOTAL_BITS-1:0]         total_next
);
    import lcsp_pkg::*;

    localparam int SUM_BITS = ((COUNT_BITS > TOTAL_BITS) ? COUNT_BITS : TOTAL_BITS) + 1;
    localparam logic [SUM_BITS-1:0] TOTAL_MAX_W =
        {{(SUM_BITS-TOTAL_BITS){1'b0}}, {TOTAL_BITS{1'b1}}};

    logic [SUM_BITS-1:0] total_w;
    logic [SUM_BITS-1:0] amount_w;
    logic [SUM_BITS-1:0] sum_w;
    logic [SUM_BITS-1:0] diff_w;

    assign total_w  = SUM_BITS'(total);
    assign amount_w = SUM_BITS'(amount);
    assign sum_w    = total_w + amount_w;
    assign diff_w   = total_w - amount_w;

    // Compare an entry against its capacity and the best so far
    assign fits   = (users < capacity);
    assign better = (users < best_users);

    // Saturate the running total at both ends
    always_comb
    begin
        unique case (mode)
            ALU_ADD:
            begin
                total_next = (sum_w > TOTAL_MAX_W) ? {TOTAL_BITS{1'b1}}
                                                   : sum_w[TOTAL_BITS-1:0];
            end
            ALU_SUB:
            begin
                total_next = (amount_w > total_w) ? {TOTAL_BITS{1'b0}}
                                                  : diff_w[TOTAL_BITS-1:0];
            end
            default:
            begin
                total_next = total;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/lcsp_table.sv */
`default_nettype none

module lcsp_table #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 88
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire lcsp_pkg::tbl_ctl_t   ctl,
    input  wire logic [ADDR_W-1:0]    rd_addr,
    input  wire logic [ADDR_W-1:0]    wr_addr,
    input  wire logic [DATA_W-1:0]    wr_data,
    output logic [DATA_W-1:0]         rd_data,
    output logic                      rd_valid
);
    import lcsp_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic [DEPTH-1:0]  valid_reg;
    logic              rd_valid_reg;

    // Write and read the entry storage
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Hold one valid bit per slot, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.set_valid)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            else if (ctl.clr_valid)
            begin
                valid_reg[wr_addr] <= 1'b0;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

`default_nettype wire

/* hdl/least_connections_server_picker.sv */
// Request: the SCAN state reads one table entry per cycle, then SCAN_TAIL and DONE give the result.
// Register, unregister, increment, decrement: read slot, apply, deliver.
// Undefined operation codes go straight to deliver. A new item is taken the cycle after the result
// is loaded; the result register lets the next item start while a result waits.
// Reset clears all valid bits, the user total, the sequencer and the result valid;
// entry contents stay undefined until registered.
`default_nettype none

module least_connections_server_picker #(
    parameter int SERVER_SLOTS = 16,
    parameter int COUNT_BITS   = 20
) (
    input  wire                                       clk,
    input  wire                                       rst_n,
    input  wire                                       req_valid,
    output logic                                      req_stall,
    input  wire logic [lcsp_pkg::OP_BITS-1:0]         operation,
    input  wire logic [lcsp_pkg::SLOT_BITS-1:0]       slot,
    input  wire logic [lcsp_pkg::ADDR_BITS-1:0]       server_address,
    input  wire logic [lcsp_pkg::PORT_BITS-1:0]       server_port,
    input  wire logic [lcsp_pkg::IN_COUNT_BITS-1:0]   capacity,
    input  wire logic [lcsp_pkg::IN_COUNT_BITS-1:0]   initial_users,
    output logic                                      rsp_valid,
    input  wire                                       rsp_stall,
    output logic [lcsp_pkg::STATUS_BITS-1:0]          status,
    output logic [lcsp_pkg::SLOT_BITS-1:0]            chosen_slot,
    output logic [lcsp_pkg::ADDR_BITS-1:0]            chosen_address,
    output logic [lcsp_pkg::PORT_BITS-1:0]            chosen_port,
    output logic [lcsp_pkg::TOTAL_BITS-1:0]           total_users
);
    import lcsp_pkg::*;

    localparam int IDX_BITS   = (SERVER_SLOTS > 1) ? $clog2(SERVER_SLOTS) : 1;
    localparam int ENTRY_BITS = ADDR_BITS + PORT_BITS + 2 * COUNT_BITS;
    localparam logic [IDX_BITS-1:0]   LAST_IDX  = IDX_BITS'(SERVER_SLOTS - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    typedef enum logic [2:0] {
        IDLE,
        SCAN,
        SCAN_TAIL,
        READ,
        APPLY,
        DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [OP_BITS-1:0]      op_reg, op_next;
    logic [IDX_BITS-1:0]     slot_reg, slot_next;
    logic [ADDR_BITS-1:0]    addr_in_reg, addr_in_next;
    logic [PORT_BITS-1:0]    port_in_reg, port_in_next;
    logic [COUNT_BITS-1:0]   cap_in_reg, cap_in_next;
    logic [COUNT_BITS-1:0]   init_in_reg, init_in_next;
    logic [IDX_BITS-1:0]     scan_idx_reg, scan_idx_next;
    logic                    eval_vld_reg, eval_vld_next;
    logic [IDX_BITS-1:0]     eval_idx_reg, eval_idx_next;
    logic                    any_reg, any_next;
    logic                    found_reg, found_next;
    logic [IDX_BITS-1:0]     best_slot_reg, best_slot_next;
    logic [COUNT_BITS-1:0]   best_users_reg, best_users_next;
    logic [ADDR_BITS-1:0]    best_addr_reg, best_addr_next;
    logic [PORT_BITS-1:0]    best_port_reg, best_port_next;
    logic [STATUS_BITS-1:0]  res_status_reg, res_status_next;
    logic [TOTAL_BITS-1:0]   total_reg, total_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    logic [STATUS_BITS-1:0]  rsp_status_reg, rsp_status_next;
    logic [SLOT_BITS-1:0]    rsp_slot_reg, rsp_slot_next;
    logic [ADDR_BITS-1:0]    rsp_addr_reg, rsp_addr_next;
    logic [PORT_BITS-1:0]    rsp_port_reg, rsp_port_next;
    logic [TOTAL_BITS-1:0]   rsp_total_reg, rsp_total_next;

    tbl_ctl_t                tbl_ctl;
    logic [IDX_BITS-1:0]     tbl_rd_addr;
    logic [ENTRY_BITS-1:0]   tbl_wr_data;
    logic [ENTRY_BITS-1:0]   tbl_rd_data;
    logic                    tbl_rd_valid;

    logic [ADDR_BITS-1:0]    ent_addr;
    logic [PORT_BITS-1:0]    ent_port;
    logic [COUNT_BITS-1:0]   ent_cap;
    logic [COUNT_BITS-1:0]   ent_users;

    alu_mode_t               alu_mode;
    logic [COUNT_BITS-1:0]   alu_amount;
    logic                    alu_fits;
    logic                    alu_better;
    logic [TOTAL_BITS-1:0]   alu_total;

    logic                    accept;
    logic                    in_table;
    logic                    out_free;
    logic                    hit;
    logic                    win;
    logic [31:0]             cap_wide;
    logic [31:0]             init_wide;
    logic [31:0]             max_wide;
    logic [COUNT_BITS-1:0]   cap_sat;
    logic [COUNT_BITS-1:0]   init_sat;

    assign req_stall = (state_reg != IDLE);
    assign accept    = req_valid && !req_stall;
    assign in_table  = (32'(slot) < SERVER_SLOTS);
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // Clamp capacity and initial users to the count range
    assign cap_wide  = 32'(capacity);
    assign init_wide = 32'(initial_users);
    assign max_wide  = 32'(COUNT_MAX);
    assign cap_sat   = (cap_wide > max_wide) ? COUNT_MAX : COUNT_BITS'(cap_wide);
    assign init_sat  = (init_wide > max_wide) ? COUNT_MAX : COUNT_BITS'(init_wide);

    assign {ent_addr, ent_port, ent_cap, ent_users} = tbl_rd_data;

    lcsp_table #(
        .DEPTH  (SERVER_SLOTS),
        .ADDR_W (IDX_BITS),
        .DATA_W (ENTRY_BITS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (tbl_ctl),
        .rd_addr  (tbl_rd_addr),
        .wr_addr  (slot_reg),
        .wr_data  (tbl_wr_data),
        .rd_data  (tbl_rd_data),
        .rd_valid (tbl_rd_valid)
    );

    lcsp_alu #(
        .COUNT_BITS (COUNT_BITS)
    ) u_alu (
        .mode       (alu_mode),
        .users      (ent_users),
        .capacity   (ent_cap),
        .best_users (best_users_reg),
        .amount     (alu_amount),
        .total      (total_reg),
        .fits       (alu_fits),
        .better     (alu_better),
        .total_next (alu_total)
    );

    // Judge the entry read in the previous scan cycle
    assign hit = eval_vld_reg && tbl_rd_valid;
    assign win = hit && alu_fits && (!found_reg || alu_better);

    // Sequence one item at a time
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        slot_next       = slot_reg;
        addr_in_next    = addr_in_reg;
        port_in_next    = port_in_reg;
        cap_in_next     = cap_in_reg;
        init_in_next    = init_in_reg;
        scan_idx_next   = scan_idx_reg;
        eval_vld_next   = 1'b0;
        eval_idx_next   = eval_idx_reg;
        any_next        = any_reg;
        found_next      = found_reg;
        best_slot_next  = best_slot_reg;
        best_users_next = best_users_reg;
        best_addr_next  = best_addr_reg;
        best_port_next  = best_port_reg;
        res_status_next = res_status_reg;
        total_next      = total_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_status_next = rsp_status_reg;
        rsp_slot_next   = rsp_slot_reg;
        rsp_addr_next   = rsp_addr_reg;
        rsp_port_next   = rsp_port_reg;
        rsp_total_next  = rsp_total_reg;
        tbl_ctl         = '0;
        tbl_rd_addr     = slot_reg;
        tbl_wr_data     = {addr_in_reg, port_in_reg, cap_in_reg, init_in_reg};
        alu_mode        = ALU_SCAN;
        alu_amount      = COUNT_ONE;

        // Fold a scanned entry into the running best
        if (hit)
        begin
            any_next = 1'b1;
        end
        if (win)
        begin
            found_next      = 1'b1;
            best_slot_next  = eval_idx_reg;
            best_users_next = ent_users;
            best_addr_next  = ent_addr;
            best_port_next  = ent_port;
        end

        unique case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    op_next         = operation;
                    slot_next       = IDX_BITS'(slot);
                    addr_in_next    = server_address;
                    port_in_next    = server_port;
                    cap_in_next     = cap_sat;
                    init_in_next    = init_sat;
                    scan_idx_next   = '0;
                    any_next        = 1'b0;
                    found_next      = 1'b0;
                    res_status_next = ST_UPDATE;
                    if (operation == OP_REQUEST)
                    begin
                        state_next = SCAN;
                    end
                    else if (in_table && (operation < OP_REQUEST))
                    begin
                        state_next = READ;
                    end
                    else
                    begin
                        state_next = DONE;
                    end
                end
            end
            SCAN:
            begin
                tbl_ctl.rd_en = 1'b1;
                tbl_rd_addr   = scan_idx_reg;
                eval_vld_next = 1'b1;
                eval_idx_next = scan_idx_reg;
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = SCAN_TAIL;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IDX_BITS'(1);
                end
            end
            SCAN_TAIL:
            begin
                priority if (!any_next)
                begin
                    res_status_next = ST_NO_SERVER;
                end
                else if (!found_next)
                begin
                    res_status_next = ST_ALL_FULL;
                end
                else
                begin
                    res_status_next = ST_ASSIGNED;
                end
                state_next = DONE;
            end
            READ:
            begin
                tbl_ctl.rd_en = 1'b1;
                state_next    = APPLY;
            end
            APPLY:
            begin
                unique case (op_reg)
                    OP_REGISTER:
                    begin
                        if (!tbl_rd_valid)
                        begin
                            tbl_ctl.wr_en     = 1'b1;
                            tbl_ctl.set_valid = 1'b1;
                            alu_mode          = ALU_ADD;
                            alu_amount        = init_in_reg;
                            total_next        = alu_total;
                        end
                    end
                    OP_UNREGISTER:
                    begin
                        if (tbl_rd_valid)
                        begin
                            tbl_ctl.clr_valid = 1'b1;
                            alu_mode          = ALU_SUB;
                            alu_amount        = ent_users;
                            total_next        = alu_total;
                        end
                    end
                    OP_INCREMENT:
                    begin
                        tbl_wr_data = {ent_addr, ent_port, ent_cap, ent_users + COUNT_ONE};
                        if (tbl_rd_valid && (ent_users != COUNT_MAX))
                        begin
                            tbl_ctl.wr_en = 1'b1;
                            alu_mode      = ALU_ADD;
                            total_next    = alu_total;
                        end
                    end
                    OP_DECREMENT:
                    begin
                        tbl_wr_data = {ent_addr, ent_port, ent_cap, ent_users - COUNT_ONE};
                        if (tbl_rd_valid && (ent_users != '0))
                        begin
                            tbl_ctl.wr_en = 1'b1;
                            alu_mode      = ALU_SUB;
                            total_next    = alu_total;
                        end
                    end
                    default:
                    begin
                        total_next = total_reg;
                    end
                endcase
                state_next = DONE;
            end
            DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_total_next  = total_reg;
                    if (res_status_reg == ST_ASSIGNED)
                    begin
                        rsp_slot_next = SLOT_BITS'(best_slot_reg);
                        rsp_addr_next = best_addr_reg;
                        rsp_port_next = best_port_reg;
                    end
                    else
                    begin
                        rsp_slot_next = '0;
                        rsp_addr_next = '0;
                        rsp_port_next = '0;
                    end
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // Hold state, item, scan progress, total and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            op_reg         <= '0;
            slot_reg       <= '0;
            addr_in_reg    <= '0;
            port_in_reg    <= '0;
            cap_in_reg     <= '0;
            init_in_reg    <= '0;
            scan_idx_reg   <= '0;
            eval_vld_reg   <= 1'b0;
            eval_idx_reg   <= '0;
            any_reg        <= 1'b0;
            found_reg      <= 1'b0;
            best_slot_reg  <= '0;
            best_users_reg <= '0;
            best_addr_reg  <= '0;
            best_port_reg  <= '0;
            res_status_reg <= ST_UPDATE;
            total_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_status_reg <= ST_UPDATE;
            rsp_slot_reg   <= '0;
            rsp_addr_reg   <= '0;
            rsp_port_reg   <= '0;
            rsp_total_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            slot_reg       <= slot_next;
            addr_in_reg    <= addr_in_next;
            port_in_reg    <= port_in_next;
            cap_in_reg     <= cap_in_next;
            init_in_reg    <= init_in_next;
            scan_idx_reg   <= scan_idx_next;
            eval_vld_reg   <= eval_vld_next;
            eval_idx_reg   <= eval_idx_next;
            any_reg        <= any_next;
            found_reg      <= found_next;
            best_slot_reg  <= best_slot_next;
            best_users_reg <= best_users_next;
            best_addr_reg  <= best_addr_next;
            best_port_reg  <= best_port_next;
            res_status_reg <= res_status_next;
            total_reg      <= total_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_status_reg <= rsp_status_next;
            rsp_slot_reg   <= rsp_slot_next;
            rsp_addr_reg   <= rsp_addr_next;
            rsp_port_reg   <= rsp_port_next;
            rsp_total_reg  <= rsp_total_next;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = rsp_status_reg;
    assign chosen_slot    = rsp_slot_reg;
    assign chosen_address = rsp_addr_reg;
    assign chosen_port    = rsp_port_reg;
    assign total_users    = rsp_total_reg;

    // Scan walks the table one slot per cycle
    a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SCAN) && (scan_idx_reg != LAST_IDX) |=>
            (scan_idx_reg == $past(scan_idx_reg) + IDX_BITS'(1)))
        else $error("scan index did not advance by one");

    // Only the apply step moves the user total
    a_total_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != APPLY) |=> $stable(total_reg))
        else $error("user total changed outside apply");

    // A server is assigned only for a request
    a_assign_req: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DONE) && (res_status_reg == ST_ASSIGNED) |->
            (op_reg == OP_REQUEST))
        else $error("server assigned for a non-request item");

    // Results without an assignment carry zero choice fields
    a_zero_choice: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_status_reg != ST_ASSIGNED) |->
            (rsp_slot_reg == '0) && (rsp_addr_reg == '0) && (rsp_port_reg == '0))
        else $error("choice fields set without an assignment");

endmodule

`default_nettype wire

/* sim/lcsp_checker.sv */
module lcsp_checker
    import lcsp_pkg::*;
(
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       req_valid,
    input  wire                       req_stall,
    input  wire [OP_BITS-1:0]         operation,
    input  wire [SLOT_BITS-1:0]       slot,
    input  wire [ADDR_BITS-1:0]       server_address,
    input  wire [PORT_BITS-1:0]       server_port,
    input  wire [IN_COUNT_BITS-1:0]   capacity,
    input  wire [IN_COUNT_BITS-1:0]   initial_users,
    input  wire                       rsp_valid,
    input  wire                       rsp_stall,
    input  wire [STATUS_BITS-1:0]     status,
    input  wire [SLOT_BITS-1:0]       chosen_slot,
    input  wire [ADDR_BITS-1:0]       chosen_address,
    input  wire [PORT_BITS-1:0]       chosen_port,
    input  wire [TOTAL_BITS-1:0]      total_users,
    output int                        mismatch_count,
    output int                        pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SLOTS = 16;
    localparam logic [IN_COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
    localparam logic [IN_COUNT_BITS-1:0] COUNT_ONE = IN_COUNT_BITS'(1);
    localparam int REPORT_LIMIT = 60;

    typedef struct {
        logic [STATUS_BITS-1:0] status;
        logic [SLOT_BITS-1:0]   slot;
        logic [ADDR_BITS-1:0]   address;
        logic [PORT_BITS-1:0]   port;
        logic [TOTAL_BITS-1:0]  total;
    } answer_t;

    // Shadow copy of the server table
    logic                     slot_used  [TABLE_SLOTS];
    logic [ADDR_BITS-1:0]     slot_addr  [TABLE_SLOTS];
    logic [PORT_BITS-1:0]     slot_port  [TABLE_SLOTS];
    logic [IN_COUNT_BITS-1:0] slot_cap   [TABLE_SLOTS];
    logic [IN_COUNT_BITS-1:0] slot_users [TABLE_SLOTS];
    logic [TOTAL_BITS-1:0]    user_sum;

    answer_t answer_q [$];
    int      reports = 0;

    initial begin
        mismatch_count = 0;
        pending_count  = 0;
    end

    function automatic logic [TOTAL_BITS-1:0] sum_plus(logic [TOTAL_BITS-1:0] base,
                                                       logic [IN_COUNT_BITS-1:0] amount);
        logic [TOTAL_BITS:0] wide;
        wide = (TOTAL_BITS+1)'(base) + (TOTAL_BITS+1)'(amount);
        return (wide > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : wide[TOTAL_BITS-1:0];
    endfunction

    function automatic logic [TOTAL_BITS-1:0] sum_minus(logic [TOTAL_BITS-1:0] base,
                                                        logic [IN_COUNT_BITS-1:0] amount);
        return (TOTAL_BITS'(amount) > base) ? '0 : base - TOTAL_BITS'(amount);
    endfunction

    // Apply one operation to the shadow table and return the answer it gives
    function automatic answer_t pick_or_update(logic [OP_BITS-1:0] op,
                                               logic [SLOT_BITS-1:0] sl,
                                               logic [ADDR_BITS-1:0] addr,
                                               logic [PORT_BITS-1:0] port,
                                               logic [IN_COUNT_BITS-1:0] cap,
                                               logic [IN_COUNT_BITS-1:0] init);
        answer_t                  ans;
        logic                     any_used;
        logic                     found;
        int                       best;
        logic [IN_COUNT_BITS-1:0] best_users;
        ans.status  = ST_UPDATE;
        ans.slot    = '0;
        ans.address = '0;
        ans.port    = '0;
        any_used    = 1'b0;
        found       = 1'b0;
        best        = 0;
        best_users  = '0;
        case (op)
            OP_REQUEST: begin
                // Scan for the least loaded server below capacity, lowest slot on a tie
                for (int i = 0; i < TABLE_SLOTS; i++) begin
                    if (slot_used[i]) begin
                        any_used = 1'b1;
                        if (slot_users[i] < slot_cap[i] &&
                            (!found || slot_users[i] < best_users)) begin
                            found      = 1'b1;
                            best       = i;
                            best_users = slot_users[i];
                        end
                    end
                end
                if (!any_used) begin
                    ans.status = ST_NO_SERVER;
                end
                else if (!found) begin
                    ans.status = ST_ALL_FULL;
                end
                else begin
                    ans.status  = ST_ASSIGNED;
                    ans.slot    = best[SLOT_BITS-1:0];
                    ans.address = slot_addr[best];
                    ans.port    = slot_port[best];
                end
            end
            OP_REGISTER: begin
                // Occupied slot keeps its entry and the total
                if (!slot_used[sl]) begin
                    slot_used[sl]  = 1'b1;
                    slot_addr[sl]  = addr;
                    slot_port[sl]  = port;
                    slot_cap[sl]   = cap;
                    slot_users[sl] = init;
                    user_sum       = sum_plus(user_sum, init);
                end
            end
            OP_UNREGISTER: begin
                if (slot_used[sl]) begin
                    user_sum      = sum_minus(user_sum, slot_users[sl]);
                    slot_used[sl] = 1'b0;
                end
            end
            OP_INCREMENT: begin
                if (slot_used[sl] && slot_users[sl] < COUNT_MAX) begin
                    slot_users[sl] = slot_users[sl] + COUNT_ONE;
                    user_sum       = sum_plus(user_sum, COUNT_ONE);
                end
            end
            OP_DECREMENT: begin
                if (slot_used[sl] && slot_users[sl] != '0) begin
                    slot_users[sl] = slot_users[sl] - COUNT_ONE;
                    user_sum       = sum_minus(user_sum, COUNT_ONE);
                end
            end
            default: begin
            end
        endcase
        ans.total = user_sum;
        return ans;
    endfunction

    task automatic report(string field, logic [31:0] want, logic [31:0] got);
        if (reports < REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        reports++;
    endtask

    // Watch both channels: compare each result transfer, predict each request transfer
    always @(posedge clk) begin
        answer_t want;
        logic    bad;
        if (!rst_n) begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                slot_used[i] = 1'b0;
            end
            user_sum = '0;
            answer_q.delete();
        end
        else begin
            if (rsp_valid && !rsp_stall) begin
                if (answer_q.size() == 0) begin
                    if (reports < REPORT_LIMIT)
                        $display("%0t: result transfer with nothing expected, status %0h",
                                 $time, status);
                    reports++;
                    mismatch_count++;
                end
                else begin
                    want = answer_q.pop_front();
                    bad  = 1'b0;
                    if (status !== want.status) begin
                        report("status", 32'(want.status), 32'(status));
                        bad = 1'b1;
                    end
                    if (chosen_slot !== want.slot) begin
                        report("chosen_slot", 32'(want.slot), 32'(chosen_slot));
                        bad = 1'b1;
                    end
                    if (chosen_address !== want.address) begin
                        report("chosen_address", want.address, chosen_address);
                        bad = 1'b1;
                    end
                    if (chosen_port !== want.port) begin
                        report("chosen_port", 32'(want.port), 32'(chosen_port));
                        bad = 1'b1;
                    end
                    if (total_users !== want.total) begin
                        report("total_users", 32'(want.total), 32'(total_users));
                        bad = 1'b1;
                    end
                    if (bad)
                        mismatch_count++;
                end
            end
            if (req_valid && !req_stall) begin
                answer_q.push_back(pick_or_update(operation, slot, server_address,
                                                  server_port, capacity, initial_users));
            end
        end
        pending_count = answer_q.size();
    end

endmodule

/* sim/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lcsp_pkg::*;

    localparam real HALF_PERIOD     = 6.0;
    localparam int  HOLD_OFF_CYCLES = 300;
    localparam int  DRAIN_CYCLES    = 40;
    localparam int  PHASE_ITEMS     = 400;

    // Spare operation codes the block must answer without effect
    localparam logic [OP_BITS-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_BITS-1:0] OP_SPARE_MID = 3'd6;
    localparam logic [OP_BITS-1:0] OP_SPARE_HI = 3'd7;

    logic                     clk            = 1'b0;
    logic                     rst_n          = 1'b0;
    logic                     req_valid      = 1'b0;
    logic                     req_stall;
    logic [OP_BITS-1:0]       operation      = '0;
    logic [SLOT_BITS-1:0]     slot           = '0;
    logic [ADDR_BITS-1:0]     server_address = '0;
    logic [PORT_BITS-1:0]     server_port    = '0;
    logic [IN_COUNT_BITS-1:0] capacity       = '0;
    logic [IN_COUNT_BITS-1:0] initial_users  = '0;
    logic                     rsp_valid;
    logic                     rsp_stall      = 1'b0;
    logic [STATUS_BITS-1:0]   status;
    logic [SLOT_BITS-1:0]     chosen_slot;
    logic [ADDR_BITS-1:0]     chosen_address;
    logic [PORT_BITS-1:0]     chosen_port;
    logic [TOTAL_BITS-1:0]    total_users;
    int                       mismatch_count;
    int                       pending_count;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_off_go    = 1'b0;

    least_connections_server_picker u_dut (.*);

    lcsp_checker u_check (.*);

    always #(HALF_PERIOD) clk = ~clk;

    // Time limit on the whole run
    initial begin
        #5_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // Response side: random stall, with one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_off_go) begin
                hold_off_go = 1'b0;
                rsp_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Offer one request and hold it until the transfer
    task automatic send_item(logic [OP_BITS-1:0] op, logic [SLOT_BITS-1:0] sl,
                             logic [ADDR_BITS-1:0] addr, logic [PORT_BITS-1:0] port,
                             logic [IN_COUNT_BITS-1:0] cap, logic [IN_COUNT_BITS-1:0] init);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid      <= 1'b1;
        operation      <= op;
        slot           <= sl;
        server_address <= addr;
        server_port    <= port;
        capacity       <= cap;
        initial_users  <= init;
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    // Mostly small capacities so requests see a mix of free and full servers
    task automatic send_random_item();
        logic [OP_BITS-1:0]       op;
        logic [IN_COUNT_BITS-1:0] cap;
        logic [IN_COUNT_BITS-1:0] init;
        int                       pick;
        pick = $urandom_range(99);
        if (pick < 20)
            op = OP_REGISTER;
        else if (pick < 32)
            op = OP_UNREGISTER;
        else if (pick < 57)
            op = OP_INCREMENT;
        else if (pick < 77)
            op = OP_DECREMENT;
        else if (pick < 97)
            op = OP_REQUEST;
        else
            op = OP_BITS'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        if ($urandom_range(4) == 0) begin
            cap  = IN_COUNT_BITS'($urandom);
            init = IN_COUNT_BITS'($urandom);
        end
        else begin
            cap  = IN_COUNT_BITS'($urandom_range(24));
            init = IN_COUNT_BITS'($urandom_range(32'(cap) + 2));
        end
        send_item(op, SLOT_BITS'($urandom_range(15)), ADDR_BITS'($urandom),
                  PORT_BITS'($urandom_range(16'hFFFF)), cap, init);
    endtask

    task automatic run_phase(int count, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_random_item();
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, extremes, ignored updates, saturation, tie break
        send_item(OP_REQUEST, 4'd0, '0, '0, '0, '0);
        send_item(OP_INCREMENT, 4'd5, '1, '1, '1, '1);
        send_item(OP_DECREMENT, 4'd5, '0, '0, '0, '0);
        send_item(OP_UNREGISTER, 4'd5, '0, '0, '0, '0);
        send_item(OP_REGISTER, 4'd0, '1, '1, '1, '1);
        send_item(OP_INCREMENT, 4'd0, '0, '0, '0, '0);
        send_item(OP_REQUEST, 4'd15, '1, '1, '1, '1);
        send_item(OP_REGISTER, 4'd15, '0, '0, '0, '0);
        send_item(OP_DECREMENT, 4'd15, '0, '0, '0, '0);
        send_item(OP_REQUEST, 4'd0, '0, '0, '0, '0);
        send_item(OP_REGISTER, 4'd0, 32'h0A00_0001, 16'd80, 20'd5, 20'd1);
        send_item(OP_DECREMENT, 4'd0, '0, '0, '0, '0);
        send_item(OP_REQUEST, 4'd0, '0, '0, '0, '0);
        send_item(OP_REGISTER, 4'd3, 32'hC0A8_0003, 16'd8003, 20'd10, 20'd2);
        send_item(OP_REGISTER, 4'd7, 32'hC0A8_0007, 16'd8007, 20'd10, 20'd2);
        send_item(OP_REQUEST, 4'd0, '0, '0, '0, '0);
        send_item(OP_INCREMENT, 4'd3, '0, '0, '0, '0);
        send_item(OP_REQUEST, 4'd0, '0, '0, '0, '0);
        send_item(OP_SPARE_LO, 4'd3, '1, '1, '1, '1);
        send_item(OP_SPARE_MID, 4'd7, '1, '1, '1, '1);
        send_item(OP_SPARE_HI, 4'd15, '1, '1, '1, '1);
        send_item(OP_UNREGISTER, 4'd0, '0, '0, '0, '0);
        send_item(OP_UNREGISTER, 4'd3, '0, '0, '0, '0);
        send_item(OP_REQUEST, 4'd0, '0, '0, '0, '0);

        // Random: no idling, then a long response hold-off, then idling on each side
        run_phase(PHASE_ITEMS, 0, 0);
        hold_off_go = 1'b1;
        run_phase(60, 0, 0);
        run_phase(PHASE_ITEMS, 54, 0);
        run_phase(PHASE_ITEMS, 0, 54);
        run_phase(PHASE_ITEMS, 22, 22);

        // Drain outstanding results, then let the pipeline settle
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
